// ----- rtl/graph_bfs_dfs_engine_macros.svh -----
// Assertion macros for the graph walk engine
`ifndef GRAPH_BFS_DFS_ENGINE_MACROS_SVH
`define GRAPH_BFS_DFS_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GBD_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBD_ASSERT(label, clk, rst, prop, msg)
`define GBD_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/gbd_pkg.sv -----
`default_nettype none
package gbd_pkg;
   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES = 256;
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int PW = EW + 1;
   localparam int CW = 7;
   localparam int DW = VW + 1;
   localparam logic [PW-1:0] NIL_EDGE = PW'(MAX_EDGES);

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_BFS = 2'd1;
   localparam logic [1:0] ACT_DFS = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [2:0] ST_VISIT = 3'd0;
   localparam logic [2:0] ST_STORED = 3'd1;
   localparam logic [2:0] ST_RANGE = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_BADSTART = 3'd4;
   localparam logic [2:0] ST_CLEARED = 3'd5;

   localparam logic [0:0] REG_VERTEX_COUNT = 1'd0;

   typedef struct packed {
      logic [1:0] action;
      logic [5:0] source_vertex;
      logic [5:0] dest_vertex;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] vertex;
      logic       last;
   } rsp_type;

   typedef enum logic [4:0] {
      S_BOOT,
      S_IDLE,
      S_ADD,
      S_BAD,
      S_CLR,
      S_CDONE,
      S_VCLR,
      S_BPOP,
      S_BRD,
      S_BHD,
      S_BEDGE,
      S_BTGT,
      S_BCHK,
      S_DPUSH,
      S_DTOP,
      S_DCUR,
      S_DTGT,
      S_DCHK,
      S_VISIT,
      S_FIN
   } state_type;
endpackage
`default_nettype wire

// ----- rtl/gbd_csr.sv -----
`default_nettype none
module gbd_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [0:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output logic      [gbd_pkg::DW-1:0] active_count
);
   logic [gbd_pkg::CW-1:0] count_ff, count_in;

   assign pready = 1'b1;
   always_comb begin
      count_in = count_ff;
      if (psel && penable && pwrite && paddr == gbd_pkg::REG_VERTEX_COUNT)
         count_in = pwdata[gbd_pkg::CW-1:0];
   end
   always_ff @(posedge clock) begin
      if (reset) count_ff <= gbd_pkg::CW'(64);
      else count_ff <= count_in;
   end
   assign prdata = (paddr == gbd_pkg::REG_VERTEX_COUNT) ? 32'(count_ff) : 32'd0;
   // clamp to capacity
   assign active_count = (count_ff > gbd_pkg::CW'(gbd_pkg::MAX_VERTICES)) ?
      gbd_pkg::DW'(gbd_pkg::MAX_VERTICES) : gbd_pkg::DW'(count_ff);
endmodule
`default_nettype wire

// ----- rtl/graph_bfs_dfs_engine.sv -----
`default_nettype none
// Graph walk engine: adjacency lists of a directed graph in a 256-entry pool.
// req channel (valid/ready) carries action, source_vertex, dest_vertex:
//   add edge, breadth-first walk, depth-first walk (preorder, newest edge
//   first), or clear graph. rsp channel carries status, vertex, last; every
//   item yields one or more transfers, the final one with last set.
// csr port (APB, pready always high) holds vertex_count at address 0.
// One item at a time: req_ready is high only while idle. Clear sweeps the
// 64 list heads. A walk first sweeps the visited map, then reads the edge
// lists of the vertices it reaches.
// Visits wait in a pending register, one visit behind, before the output
// register, so the last flag is known when the final visit is sent. When
// the receiver stalls the output register holds its transfer and the walk
// halts at the next visit.
// Reset empties the lists (a sweep of the 64 list heads during which
// req_ready is low), clears the edge count and sets vertex_count to 64.
module graph_bfs_dfs_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire gbd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output gbd_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [0:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready
);
   localparam int VW = gbd_pkg::VW;
   localparam int PW = gbd_pkg::PW;
   localparam int EW = gbd_pkg::EW;
   localparam int DW = gbd_pkg::DW;

   logic [DW-1:0] vc;
   gbd_csr u_csr (.clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .active_count(vc));

   // memories
   logic [PW-1:0] head_mem [gbd_pkg::MAX_VERTICES];
   logic [VW-1:0] tgt_mem  [gbd_pkg::MAX_EDGES];
   logic [PW-1:0] nxt_mem  [gbd_pkg::MAX_EDGES];
   logic [VW-1:0] work_mem [gbd_pkg::MAX_VERTICES];
   logic [PW-1:0] cur_mem  [gbd_pkg::MAX_VERTICES];
   logic          vis_mem  [gbd_pkg::MAX_VERTICES];

   gbd_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   gbd_pkg::req_type   req_ff, req_in;
   logic [PW-1:0] used_ff, used_in;
   logic [DW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] qh_ff, qh_in, qt_ff, qt_in;
   logic [PW-1:0] edge_ff, edge_in;
   logic [VW-1:0] vtx_ff, vtx_in, tgt_ff, tgt_in, pend_ff, pend_in;
   logic          pend_v_ff, pend_v_in;
   logic          rv_ff, rv_in;
   gbd_pkg::rsp_type rd_ff, rd_in;

   // registered read data
   logic [PW-1:0] head_rd_ff, nxt_rd_ff, cur_rd_ff;
   logic [VW-1:0] tgt_rd_ff, work_rd_ff;
   logic          vis_rd_ff;
   logic [VW-1:0] head_ra, work_ra, cur_ra, vis_ra;
   logic [EW-1:0] edge_ra;

   // write controls
   logic head_we; logic [VW-1:0] head_wa; logic [PW-1:0] head_wd;
   logic edge_we;
   logic work_we; logic [VW-1:0] work_wa; logic [VW-1:0] work_wd;
   logic cur_we;  logic [VW-1:0] cur_wa;  logic [PW-1:0] cur_wd;
   logic vis_we;  logic [VW-1:0] vis_wa;  logic vis_wd;

   logic          rsp_free, src_ok, add_range, pool_full, take_edge;
   logic [DW-1:0] dtop;

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd_ff <= head_mem[head_ra];
      if (edge_we) begin
         tgt_mem[used_ff[EW-1:0]] <= req_ff.dest_vertex;
         nxt_mem[used_ff[EW-1:0]] <= head_rd_ff;
      end
      tgt_rd_ff <= tgt_mem[edge_ra];
      nxt_rd_ff <= nxt_mem[edge_ra];
      if (work_we) work_mem[work_wa] <= work_wd;
      work_rd_ff <= work_mem[work_ra];
      if (cur_we) cur_mem[cur_wa] <= cur_wd;
      cur_rd_ff <= cur_mem[cur_ra];
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      vis_rd_ff <= vis_mem[vis_ra];
   end

   assign rsp_free = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == gbd_pkg::S_IDLE);
   assign dtop = qt_ff - DW'(1);
   assign src_ok = DW'(req_data.source_vertex) < vc;
   assign add_range = (DW'(req_ff.source_vertex) >= vc) || (DW'(req_ff.dest_vertex) >= vc);
   assign pool_full = used_ff >= PW'(gbd_pkg::MAX_EDGES);
   // one compare serves both walks: target in range, unseen, room on the list
   assign take_edge = (DW'(tgt_ff) < vc) && !vis_rd_ff &&
      (qt_ff < DW'(gbd_pkg::MAX_VERTICES));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbd_pkg::S_BOOT: if (cnt_ff[VW]) state_in = gbd_pkg::S_IDLE;
         gbd_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_data.action)
                  gbd_pkg::ACT_ADD: state_in = gbd_pkg::S_ADD;
                  gbd_pkg::ACT_CLEAR: state_in = gbd_pkg::S_CLR;
                  default: state_in = src_ok ? gbd_pkg::S_VCLR : gbd_pkg::S_BAD;
               endcase
            end
         end
         gbd_pkg::S_ADD: if (rsp_free) state_in = gbd_pkg::S_IDLE;
         gbd_pkg::S_BAD: if (rsp_free) state_in = gbd_pkg::S_IDLE;
         gbd_pkg::S_CLR: if (cnt_ff[VW]) state_in = gbd_pkg::S_CDONE;
         gbd_pkg::S_CDONE: if (rsp_free) state_in = gbd_pkg::S_IDLE;
         gbd_pkg::S_VCLR: begin
            if (cnt_ff[VW]) state_in = (req_ff.action == gbd_pkg::ACT_BFS) ?
               gbd_pkg::S_BPOP : gbd_pkg::S_DPUSH;
         end
         gbd_pkg::S_BPOP:
            state_in = (qh_ff == qt_ff) ? gbd_pkg::S_FIN : gbd_pkg::S_BRD;
         gbd_pkg::S_BRD: state_in = gbd_pkg::S_BHD;
         gbd_pkg::S_BHD: state_in = gbd_pkg::S_VISIT;
         gbd_pkg::S_BEDGE:
            state_in = edge_ff[EW] ? gbd_pkg::S_BPOP : gbd_pkg::S_BTGT;
         gbd_pkg::S_BTGT: state_in = gbd_pkg::S_BCHK;
         gbd_pkg::S_BCHK: state_in = gbd_pkg::S_BEDGE;
         gbd_pkg::S_DPUSH: state_in = gbd_pkg::S_VISIT;
         gbd_pkg::S_DTOP:
            state_in = (qt_ff == '0) ? gbd_pkg::S_FIN : gbd_pkg::S_DCUR;
         gbd_pkg::S_DCUR:
            state_in = cur_rd_ff[EW] ? gbd_pkg::S_DTOP : gbd_pkg::S_DTGT;
         gbd_pkg::S_DTGT: state_in = gbd_pkg::S_DCHK;
         gbd_pkg::S_DCHK:
            state_in = take_edge ? gbd_pkg::S_DPUSH : gbd_pkg::S_DTOP;
         gbd_pkg::S_VISIT: if (!pend_v_ff || rsp_free) state_in = ret_ff;
         gbd_pkg::S_FIN: if (rsp_free) state_in = gbd_pkg::S_IDLE;
         default: state_in = gbd_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in = req_ff; used_in = used_ff; cnt_in = cnt_ff; ret_in = ret_ff;
      qh_in = qh_ff; qt_in = qt_ff; edge_in = edge_ff; vtx_in = vtx_ff;
      tgt_in = tgt_ff; pend_in = pend_ff; pend_v_in = pend_v_ff;
      rv_in = rv_ff && !rsp_ready; rd_in = rd_ff;
      head_ra = req_ff.source_vertex; work_ra = qh_ff[VW-1:0];
      cur_ra = dtop[VW-1:0]; vis_ra = '0; edge_ra = edge_ff[EW-1:0];
      head_we = 1'b0; head_wa = '0; head_wd = used_ff;
      edge_we = 1'b0;
      work_we = 1'b0; work_wa = '0; work_wd = tgt_ff;
      cur_we = 1'b0; cur_wa = dtop[VW-1:0]; cur_wd = head_rd_ff;
      vis_we = 1'b0; vis_wa = '0; vis_wd = 1'b0;
      case (state_ff)
         gbd_pkg::S_BOOT, gbd_pkg::S_CLR: begin
            // sweep the list heads to empty
            head_we = !cnt_ff[VW]; head_wa = cnt_ff[VW-1:0]; head_wd = gbd_pkg::NIL_EDGE;
            cnt_in = cnt_ff + DW'(1);
            used_in = '0;
         end
         gbd_pkg::S_IDLE: begin
            head_ra = req_data.source_vertex;
            if (req_valid) begin
               req_in = req_data; cnt_in = '0;
            end
         end
         gbd_pkg::S_ADD: begin
            // head_rd_ff holds the source list head
            if (rsp_free) begin
               rv_in = 1'b1; rd_in.vertex = '0; rd_in.last = 1'b1;
               if (add_range) rd_in.status = gbd_pkg::ST_RANGE;
               else if (pool_full) rd_in.status = gbd_pkg::ST_FULL;
               else begin
                  rd_in.status = gbd_pkg::ST_STORED;
                  edge_we = 1'b1;
                  head_we = 1'b1; head_wa = req_ff.source_vertex; head_wd = used_ff;
                  used_in = used_ff + PW'(1);
               end
            end
         end
         gbd_pkg::S_BAD: begin
            if (rsp_free) begin
               rv_in = 1'b1; rd_in.status = gbd_pkg::ST_BADSTART;
               rd_in.vertex = '0; rd_in.last = 1'b1;
            end
         end
         gbd_pkg::S_CDONE: begin
            if (rsp_free) begin
               rv_in = 1'b1; rd_in.status = gbd_pkg::ST_CLEARED;
               rd_in.vertex = '0; rd_in.last = 1'b1;
            end
         end
         gbd_pkg::S_VCLR: begin
            vis_we = !cnt_ff[VW]; vis_wa = cnt_ff[VW-1:0]; vis_wd = 1'b0;
            cnt_in = cnt_ff + DW'(1);
            if (cnt_ff[VW]) begin
               // mark the start and place it on the work list
               vis_we = 1'b1; vis_wa = req_ff.source_vertex; vis_wd = 1'b1;
               work_we = 1'b1; work_wa = '0; work_wd = req_ff.source_vertex;
               qh_in = '0; qt_in = DW'(1);
               vtx_in = req_ff.source_vertex; pend_v_in = 1'b0;
            end
         end
         gbd_pkg::S_BRD: begin
            vtx_in = work_rd_ff; head_ra = work_rd_ff;
            qh_in = qh_ff + DW'(1);
         end
         gbd_pkg::S_BHD: begin
            edge_in = head_rd_ff; ret_in = gbd_pkg::S_BEDGE;
         end
         gbd_pkg::S_BTGT: begin
            tgt_in = tgt_rd_ff; vis_ra = tgt_rd_ff; edge_in = nxt_rd_ff;
         end
         gbd_pkg::S_BCHK: begin
            if (take_edge) begin
               vis_we = 1'b1; vis_wa = tgt_ff; vis_wd = 1'b1;
               work_we = 1'b1; work_wa = qt_ff[VW-1:0]; work_wd = tgt_ff;
               qt_in = qt_ff + DW'(1);
            end
         end
         gbd_pkg::S_DPUSH: begin
            // head_rd_ff holds the list head of the vertex just reached
            cur_we = 1'b1; cur_wa = dtop[VW-1:0]; cur_wd = head_rd_ff;
            ret_in = gbd_pkg::S_DTOP;
         end
         gbd_pkg::S_DCUR: begin
            edge_ra = cur_rd_ff[EW-1:0];
            if (cur_rd_ff[EW]) qt_in = dtop;
         end
         gbd_pkg::S_DTGT: begin
            cur_we = 1'b1; cur_wa = dtop[VW-1:0]; cur_wd = nxt_rd_ff;
            tgt_in = tgt_rd_ff; vis_ra = tgt_rd_ff; head_ra = tgt_rd_ff;
         end
         gbd_pkg::S_DCHK: begin
            head_ra = tgt_ff;
            if (take_edge) begin
               vis_we = 1'b1; vis_wa = tgt_ff; vis_wd = 1'b1;
               qt_in = qt_ff + DW'(1); vtx_in = tgt_ff;
            end
         end
         gbd_pkg::S_VISIT: begin
            // send the previous visit, hold the new one back
            if (!pend_v_ff || rsp_free) begin
               if (pend_v_ff) begin
                  rv_in = 1'b1; rd_in.status = gbd_pkg::ST_VISIT;
                  rd_in.vertex = pend_ff; rd_in.last = 1'b0;
               end
               pend_v_in = 1'b1; pend_in = vtx_ff;
            end
         end
         gbd_pkg::S_FIN: begin
            if (rsp_free) begin
               rv_in = 1'b1; rd_in.status = gbd_pkg::ST_VISIT;
               rd_in.vertex = pend_ff; rd_in.last = 1'b1;
               pend_v_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbd_pkg::S_BOOT; ret_ff <= gbd_pkg::S_IDLE;
         used_ff <= '0; cnt_ff <= '0; rv_ff <= 1'b0; pend_v_ff <= 1'b0;
         qh_ff <= '0; qt_ff <= '0; req_ff <= '0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in;
         used_ff <= used_in; cnt_ff <= cnt_in; rv_ff <= rv_in; pend_v_ff <= pend_v_in;
         qh_ff <= qh_in; qt_ff <= qt_in; req_ff <= req_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff <= edge_in; vtx_ff <= vtx_in; tgt_ff <= tgt_in; pend_ff <= pend_in;
      rd_ff <= rd_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data = rd_ff;

`include "graph_bfs_dfs_engine_macros.svh"
   `GBD_ASSERT(a_busy_no_req, clock, reset, (state_ff != gbd_pkg::S_IDLE) |-> !req_ready, "ready while busy")
   `GBD_ASSERT(a_pool_bound, clock, reset, used_ff <= PW'(gbd_pkg::MAX_EDGES), "pool overflow")
   `GBD_ASSERT(a_stack_bound, clock, reset, qt_ff <= DW'(gbd_pkg::MAX_VERTICES), "work list overflow")
   `GBD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result dropped while stalled")
endmodule
`default_nettype wire
